### src/dia_pkg.sv
// Shared types and constants for the descriptor index allocator.
// No dependencies; every other file imports this package.
`default_nettype none
package dia_pkg;

	localparam int SLOT_W     = 12;
	localparam int HEAP_DEPTH = 1 << SLOT_W;
	localparam int CNT_W      = SLOT_W + 1;
	localparam int CAP_W      = 13;
	localparam int STRIDE_W   = 16;
	localparam int HANDLE_W   = 64;
	localparam int PROD_W     = STRIDE_W + SLOT_W;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VISIBLE  = 3'd4;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic              data;
	} map_wr_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic [SLOT_W-1:0] data;
	} stk_wr_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic                with_h;
		logic [STATUS_W-1:0] status;
		logic [PROD_W-1:0]   prod;
	} hg_req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] cpu_base;
		logic [HANDLE_W-1:0] gpu_base;
		logic                visible;
	} hcfg_t;

endpackage
`default_nettype wire

### src/dia_if.sv
// Request and response channel interfaces for the allocator.
// Depends on dia_pkg.
`default_nettype none
interface dia_req_if import dia_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [SLOT_W-1:0] slot;
	modport source (output valid, output cmd, output slot, input ready);
	modport sink (input valid, input cmd, input slot, output ready);
endinterface

interface dia_rsp_if import dia_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SLOT_W-1:0]   slot_out;
	logic [HANDLE_W-1:0] cpu_handle;
	logic [HANDLE_W-1:0] gpu_handle;
	logic                gpu_valid;
	logic [STATUS_W-1:0] status;
	modport source (output valid, output slot_out, output cpu_handle, output gpu_handle,
		output gpu_valid, output status, input ready);
	modport sink (input valid, input slot_out, input cpu_handle, input gpu_handle,
		input gpu_valid, input status, output ready);
endinterface
`default_nettype wire

### src/dia_map.sv
// Slot-allocated bitmap: synchronous memory with a clearing pass after reset.
// Depends on dia_pkg.
`default_nettype none
module dia_map import dia_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [SLOT_W-1:0] rd_addr,
	input  wire map_wr_t           wr,
	output logic                   rd_data,
	output logic                   ready
);

	logic             mem [HEAP_DEPTH];
	logic [CNT_W-1:0] clr_q;
	logic             clr_active;

	assign clr_active = ~clr_q[CNT_W-1];
	assign ready      = ~clr_active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clr_active) begin
			clr_q <= clr_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_active) begin
			mem[clr_q[SLOT_W-1:0]] <= 1'b0;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

### src/dia_stack.sv
// Freed-slot stack storage: one write and one read port, registered read.
// Depends on dia_pkg.
`default_nettype none
module dia_stack import dia_pkg::*; (
	input  wire logic              clk,
	input  wire logic [SLOT_W-1:0] rd_addr,
	input  wire stk_wr_t           wr,
	output logic [SLOT_W-1:0]      rd_data
);

	logic [SLOT_W-1:0] mem [HEAP_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

### src/dia_hgen.sv
// Handle adder and response register: base plus stride product, 64-bit wrap.
// Depends on dia_pkg and dia_if.
`default_nettype none
module dia_hgen import dia_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire hg_req_t hg,
	input  wire hcfg_t   cfg,
	output logic         space,
	dia_rsp_if.source    rsp
);

	logic [HANDLE_W-1:0] off;
	logic                valid_q;

	assign off   = {{(HANDLE_W-PROD_W){1'b0}}, hg.prod};
	assign space = ~valid_q | rsp.ready;
	assign rsp.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			rsp.slot_out   <= hg.slot;
			rsp.cpu_handle <= hg.with_h ? cfg.cpu_base + off : '0;
			rsp.gpu_handle <= (hg.with_h && cfg.visible) ? cfg.gpu_base + off : '0;
			rsp.gpu_valid  <= cfg.visible;
			rsp.status     <= hg.status;
		end
	end

endmodule
`default_nettype wire

### src/descriptor_index_allocator_core.sv
// Each accepted item goes through read, update and multiply, and handle add,
// and no new item is taken until it leaves DONE (it stalls there without space).
// The response register lets the next item enter while a result waits.
// After reset the slot bitmap is cleared first; no item is taken
// until then, configuration writes are taken at once.
// Depends on dia_pkg, dia_if, dia_map, dia_stack, dia_hgen.
`default_nettype none
module descriptor_index_allocator_core import dia_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	dia_req_if.sink                    req,
	dia_rsp_if.source                  rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t              state_q;
	logic [CAP_W-1:0]    capacity_q;
	logic [STRIDE_W-1:0] stride_q;
	hcfg_t               hcfg_q;
	logic [CNT_W-1:0]    fc_q, nf_q, fc_d, nf_d, lim;
	logic [CMD_W-1:0]    cmd_s1;
	logic [SLOT_W-1:0]   slot_s1, got, stk_rd;
	logic                map_rd, map_ready, space, with_h, exec, accept;
	logic [STATUS_W-1:0] st;
	map_wr_t             map_wr;
	stk_wr_t             stk_wr;
	hg_req_t             hg_s2;

	assign accept    = req.valid & req.ready;
	assign req.ready = (state_q == ST_IDLE) & map_ready;
	assign exec      = (state_q == ST_EXEC);
	assign lim       = (capacity_q > CAP_W'(HEAP_DEPTH)) ? CNT_W'(HEAP_DEPTH)
		: CNT_W'(capacity_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(4096);
			stride_q   <= STRIDE_W'(32);
			hcfg_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAPACITY: capacity_q     <= cfg_wdata[CAP_W-1:0];
				REG_STRIDE:   stride_q       <= cfg_wdata[STRIDE_W-1:0];
				REG_CPU_BASE: hcfg_q.cpu_base <= cfg_wdata[HANDLE_W-1:0];
				REG_GPU_BASE: hcfg_q.gpu_base <= cfg_wdata[HANDLE_W-1:0];
				REG_VISIBLE:  hcfg_q.visible  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// memories are read at the accept edge; writes land in EXEC, before the next read
	dia_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (req.slot),
		.wr      (map_wr),
		.rd_data (map_rd),
		.ready   (map_ready)
	);

	dia_stack u_stack (
		.clk     (clk),
		.rd_addr (SLOT_W'(fc_q - CNT_W'(1))),
		.wr      (stk_wr),
		.rd_data (stk_rd)
	);

	always_comb begin
		got    = slot_s1;
		with_h = 1'b0;
		st     = STATUS_OK;
		fc_d   = fc_q;
		nf_d   = nf_q;
		map_wr = '0;
		stk_wr = '0;
		if (cmd_s1 == CMD_ALLOC) begin
			if (fc_q != '0) begin
				got    = stk_rd;
				fc_d   = fc_q - CNT_W'(1);
				with_h = 1'b1;
				map_wr = '{en: exec, addr: stk_rd, data: 1'b1};
			end else if (nf_q < lim) begin
				got    = nf_q[SLOT_W-1:0];
				nf_d   = nf_q + CNT_W'(1);
				with_h = 1'b1;
				map_wr = '{en: exec, addr: nf_q[SLOT_W-1:0], data: 1'b1};
			end else begin
				got = '0;
				st  = STATUS_FULL;
			end
		end else if (CNT_W'(slot_s1) >= lim) begin
			st = STATUS_RANGE;
		end else if (cmd_s1 == CMD_FREE) begin
			with_h = 1'b1;
			if (!map_rd) begin
				st = STATUS_NOT_ALLOC;
			end else begin
				map_wr = '{en: exec, addr: slot_s1, data: 1'b0};
				if (fc_q < CNT_W'(HEAP_DEPTH)) begin
					stk_wr = '{en: exec, addr: fc_q[SLOT_W-1:0], data: slot_s1};
					fc_d   = fc_q + CNT_W'(1);
				end
			end
		end else begin
			with_h = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fc_q    <= '0;
			nf_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: begin
					fc_q    <= fc_d;
					nf_q    <= nf_d;
					state_q <= ST_DONE;
				end
				ST_DONE: if (space) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= req.cmd;
			slot_s1 <= req.slot;
		end
		if (exec) begin
			hg_s2.slot   <= got;
			hg_s2.with_h <= with_h;
			hg_s2.status <= st;
			hg_s2.prod   <= PROD_W'(stride_q) * PROD_W'(got);
		end
	end

	dia_hgen u_hgen (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (state_q == ST_DONE),
		.hg     (hg_s2),
		.cfg    (hcfg_q),
		.space  (space),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

### src/dia_checker.sv
// Port-level checks for the allocator core, bound to the top level.
// Depends on dia_pkg and descriptor_index_allocator_core.
`default_nettype none
module dia_checker import dia_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_ready,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire logic [SLOT_W-1:0]   slot_out,
	input wire logic [HANDLE_W-1:0] cpu_handle,
	input wire logic [HANDLE_W-1:0] gpu_handle,
	input wire logic                gpu_valid,
	input wire logic [STATUS_W-1:0] status
);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while another is in flight");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STATUS_FULL |->
		slot_out == '0 && cpu_handle == '0 && gpu_handle == '0)
		else $error("full result carries a slot or handles");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STATUS_RANGE |-> cpu_handle == '0 && gpu_handle == '0)
		else $error("out of range result carries handles");

	a_gpu_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !gpu_valid |-> gpu_handle == '0)
		else $error("gpu handle set on a heap that is not visible");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(slot_out) && $stable(status))
		else $error("stalled result changed");

endmodule

bind descriptor_index_allocator_core dia_checker u_dia_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.slot_out   (rsp.slot_out),
	.cpu_handle (rsp.cpu_handle),
	.gpu_handle (rsp.gpu_handle),
	.gpu_valid  (rsp.gpu_valid),
	.status     (rsp.status)
);
`default_nettype wire
